### sv/sfq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfq_pkg: shared types and constants for the fair queue scheduler
// Register indexes, request kinds, hash constants and the command and status
// bundles that pass between controller and datapath.
// ============================================================================
package sfq_pkg;

    // Default sizing
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 12;

    // Hash: 32-bit key folded modulo 2^20 - 1
    localparam int          HASH_W   = 32;
    localparam int          DIV_W    = 20;
    localparam logic [20:0] HASH_MOD = 21'((2 << 19) - 1);

    // Configuration port
    localparam int         CFG_ADDR_W       = 1;
    localparam logic [0:0] REG_QUEUE_LIMIT  = 1'b0;
    localparam logic [0:0] REG_BUCKET_COUNT = 1'b1;

    localparam int LIMIT_RST  = 40;
    localparam int BCOUNT_RST = 16;
    localparam int SHARE_RST  = LIMIT_RST / BCOUNT_RST;

    // Request kinds carried on tuser
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch a new request
        logic clear_wr;    // write zero to the depth store, advance sweep
        logic hash_a;      // mix the key
        logic div_start;   // launch the divider
        logic div_share;   // divider operand: queue limit instead of hash
        logic share_load;  // capture fair share from the quotient
        logic enq_rd;      // read depth of the hashed bucket
        logic enq_upd;     // admission decision and update
        logic deq_rd;      // read depth of the ring head bucket
        logic deq_upd;     // serve the head bucket
        logic out_load;    // move the result into the output register
    } sfq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep is at the final entry
        logic div_busy;
        logic ring_empty;
        logic out_free;    // output register can take a result this cycle
    } sfq_status_t;

endpackage

### sv/sfq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// sfq_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ============================================================================
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sfq_div.sv
`timescale 1ns / 1ps
// ============================================================================
// sfq_div: restoring divider, one quotient bit per cycle
// Divides a DIV_W-bit dividend by a narrow divisor; busy while the step counter runs.
// ============================================================================
module sfq_div #(
    parameter int DIVS_W = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [sfq_pkg::DIV_W-1:0] dividend,
    input  logic [DIVS_W-1:0]        divisor,
    output logic                     busy,
    output logic [sfq_pkg::DIV_W-1:0] quotient,
    output logic [DIVS_W-1:0]        remainder
);

    localparam int DW    = sfq_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [DW-1:0]     quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Shift dividend out, quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? DIVS_W'(trial - {1'b0, dsr_reg}) : trial[DIVS_W-1:0];
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/sfq_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// sfq_dp: scheduler datapath
// Hash, admission, depth and ring stores, ring pointers and result register.
// ============================================================================
module sfq_dp #(
    parameter int MAX_BUCKETS = sfq_pkg::MAX_BUCKETS_DEF,
    parameter int COUNT_WIDTH = sfq_pkg::COUNT_WIDTH_DEF,
    localparam int BIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int BCNT_W = $clog2(MAX_BUCKETS + 1),
    localparam int CFG_W  = (COUNT_WIDTH > BCNT_W) ? COUNT_WIDTH : BCNT_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfq_pkg::sfq_cmd_t             cmd,
    output sfq_pkg::sfq_status_t          status,
    input  logic [sfq_pkg::HASH_W-1:0]    src_addr,
    input  logic [sfq_pkg::HASH_W-1:0]    dst_addr,
    input  logic                          cfg_we,
    input  logic [sfq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]              cfg_wdata,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          ok,
    output logic [BIDX_W-1:0]             bucket_index,
    output logic [COUNT_WIDTH-1:0]        total_queued
);

    localparam int HW = sfq_pkg::HASH_W;
    localparam int DW = sfq_pkg::DIV_W;
    localparam int AW = CFG_W + 1;
    localparam logic [BCNT_W:0] MAX_L = (BCNT_W + 1)'(MAX_BUCKETS);

    // Configuration and scheduler state
    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [BCNT_W-1:0]      bcount_reg;
    logic [COUNT_WIDTH-1:0] share_reg;
    logic [COUNT_WIDTH-1:0] occ_reg;
    logic [BIDX_W-1:0]      head_reg;
    logic [BCNT_W-1:0]      rcount_reg;
    logic [BIDX_W-1:0]      clr_reg;

    // Request working registers
    logic [HW-1:0]          k_reg;
    logic [HW-1:0]          h_reg;
    logic signed [AW-1:0]   left_reg;
    logic [BIDX_W-1:0]      bkt_reg;
    logic                   res_ok_reg;
    logic [BIDX_W-1:0]      res_idx_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic [BIDX_W-1:0]      out_idx_reg;
    logic [COUNT_WIDTH-1:0] out_tot_reg;

    logic [BCNT_W-1:0]      eff;
    logic [DW:0]            fold_sum;
    logic [DW-1:0]          fold;
    logic [DW-1:0]          div_dividend;
    logic                   div_busy;
    logic [DW-1:0]          div_quo;
    logic [BCNT_W-1:0]      div_rem;

    logic [COUNT_WIDTH-1:0] depth_rdata;
    logic [BIDX_W-1:0]      depth_raddr;
    logic [BIDX_W-1:0]      depth_waddr;
    logic [COUNT_WIDTH-1:0] depth_wdata;
    logic                   depth_we;
    logic [BIDX_W-1:0]      ring_rdata;
    logic [BIDX_W-1:0]      ring_wdata;
    logic                   ring_we;
    logic [BCNT_W:0]        tail_sum;
    logic [BIDX_W-1:0]      tail;
    logic [BIDX_W-1:0]      head_inc;

    logic signed [AW-1:0]   used_s;
    logic signed [AW-1:0]   eff_s;
    logic signed [AW-1:0]   share_s;
    logic                   drop;
    logic                   admit;
    logic [COUNT_WIDTH-1:0] used_inc;
    logic [COUNT_WIDTH-1:0] depth_dec;

    // Bucket count clamped to 1 .. MAX_BUCKETS
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            eff = BCNT_W'(1);
        end
        else if (bcount_reg > BCNT_W'(MAX_BUCKETS))
        begin
            eff = BCNT_W'(MAX_BUCKETS);
        end
        else
        begin
            eff = bcount_reg;
        end
    end

    // Fold the mixed key modulo 2^20 - 1: high part adds back onto low part
    assign fold_sum = {1'b0, h_reg[DW-1:0]} + (DW + 1)'(h_reg[HW-1:DW]);
    assign fold     = (fold_sum >= sfq_pkg::HASH_MOD)
                    ? DW'(fold_sum - sfq_pkg::HASH_MOD) : fold_sum[DW-1:0];

    assign div_dividend = cmd.div_share ? DW'(limit_reg) : fold;

    sfq_div #(
        .DIVS_W (BCNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Admission rules
    assign used_s   = $signed(AW'(depth_rdata));
    assign eff_s    = $signed(AW'(eff));
    assign share_s  = $signed(AW'(share_reg));
    assign drop     = (left_reg <= 0) || (used_s >= (left_reg >>> 1))
                   || ((left_reg < eff_s) && (used_s > share_s));
    assign admit    = !drop;
    assign used_inc = depth_rdata + 1'b1;
    assign depth_dec = (depth_rdata != '0) ? depth_rdata - 1'b1 : depth_rdata;

    // Ring tail and head advance
    assign tail_sum = (BCNT_W + 1)'(head_reg) + (BCNT_W + 1)'(rcount_reg);
    assign tail     = (tail_sum >= MAX_L) ? BIDX_W'(tail_sum - MAX_L)
                                          : tail_sum[BIDX_W-1:0];
    assign head_inc = (head_reg == BIDX_W'(MAX_BUCKETS - 1)) ? '0 : head_reg + 1'b1;

    // Depth store ports
    assign depth_raddr = cmd.deq_rd ? ring_rdata : div_rem[BIDX_W-1:0];

    always_comb
    begin
        depth_we    = 1'b0;
        depth_waddr = bkt_reg;
        depth_wdata = used_inc;
        if (cmd.clear_wr)
        begin
            depth_we    = 1'b1;
            depth_waddr = clr_reg;
            depth_wdata = '0;
        end
        else if (cmd.enq_upd)
        begin
            depth_we = admit;
        end
        else if (cmd.deq_upd)
        begin
            depth_we    = 1'b1;
            depth_wdata = depth_dec;
        end
    end

    // Ring store ports: append on first packet, rotate a bucket that stays busy
    always_comb
    begin
        ring_wdata = bkt_reg;
        ring_we    = 1'b0;
        if (cmd.enq_upd)
        begin
            ring_we = admit && (depth_rdata == '0)
                   && (rcount_reg < BCNT_W'(MAX_BUCKETS));
        end
        else if (cmd.deq_upd)
        begin
            ring_we = (depth_dec != '0);
        end
    end

    sfq_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BUCKETS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (depth_we),
        .waddr (depth_waddr),
        .wdata (depth_wdata),
        .raddr (depth_raddr),
        .rdata (depth_rdata)
    );

    sfq_ram #(
        .WIDTH (BIDX_W),
        .DEPTH (MAX_BUCKETS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= COUNT_WIDTH'(sfq_pkg::LIMIT_RST);
            bcount_reg    <= BCNT_W'(sfq_pkg::BCOUNT_RST);
            share_reg     <= COUNT_WIDTH'(sfq_pkg::SHARE_RST);
            occ_reg       <= '0;
            head_reg      <= '0;
            rcount_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == sfq_pkg::REG_QUEUE_LIMIT))
            begin
                limit_reg <= cfg_wdata[COUNT_WIDTH-1:0];
            end
            if (cfg_we && (cfg_addr == sfq_pkg::REG_BUCKET_COUNT))
            begin
                bcount_reg <= cfg_wdata[BCNT_W-1:0];
            end
            if (cmd.share_load)
            begin
                share_reg <= div_quo[COUNT_WIDTH-1:0];
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.enq_upd && admit)
            begin
                occ_reg <= occ_reg + 1'b1;
                if (ring_we)
                begin
                    rcount_reg <= rcount_reg + 1'b1;
                end
            end
            if (cmd.deq_upd)
            begin
                if (occ_reg != '0)
                begin
                    occ_reg <= occ_reg - 1'b1;
                end
                if (depth_dec == '0)
                begin
                    rcount_reg <= rcount_reg - 1'b1;
                end
                head_reg <= head_inc;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            k_reg       <= src_addr + dst_addr;
            left_reg    <= $signed(AW'(limit_reg)) - $signed(AW'(occ_reg));
            res_ok_reg  <= 1'b0;
            res_idx_reg <= '0;
        end
        if (cmd.hash_a)
        begin
            h_reg <= k_reg + (k_reg >> 8) + ~(k_reg >> 4);
        end
        if (cmd.enq_rd)
        begin
            bkt_reg <= div_rem[BIDX_W-1:0];
        end
        if (cmd.deq_rd)
        begin
            bkt_reg <= ring_rdata;
        end
        if (cmd.enq_upd)
        begin
            res_ok_reg  <= admit;
            res_idx_reg <= bkt_reg;
        end
        if (cmd.deq_upd)
        begin
            res_ok_reg  <= 1'b1;
            res_idx_reg <= bkt_reg;
        end
        if (cmd.out_load)
        begin
            out_ok_reg  <= res_ok_reg;
            out_idx_reg <= res_idx_reg;
            out_tot_reg <= occ_reg;
        end
    end

    assign status.clear_last = (clr_reg == BIDX_W'(MAX_BUCKETS - 1));
    assign status.div_busy   = div_busy;
    assign status.ring_empty = (rcount_reg == '0);
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid      = out_valid_reg;
    assign ok           = out_ok_reg;
    assign bucket_index = out_idx_reg;
    assign total_queued = out_tot_reg;

    // Ring never holds more buckets than exist
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= BCNT_W'(MAX_BUCKETS))
        else $error("ring count beyond bucket count");

    // Occupancy moves by at most one packet per cycle
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == $past(occ_reg))
        || (occ_reg == COUNT_WIDTH'($past(occ_reg) + 1'b1))
        || (occ_reg == COUNT_WIDTH'($past(occ_reg) - 1'b1)))
        else $error("occupancy jumped");

    // A result never overwrites one still waiting downstream
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    // Hash path never relaunches the divider mid-run
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start && !cmd.div_share) |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

### sv/sfq_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// sfq_ctrl: scheduler controller
// Sequences reset sweep, fair share updates, enqueue and dequeue requests.
// ============================================================================
module sfq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    input  logic                 req_type,
    input  logic                 cfg_we,
    input  sfq_pkg::sfq_status_t status,
    output logic                 s_ready,
    output sfq_pkg::sfq_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_CLEAR      = 12'b0000_0000_0001,
        S_SHARE_GO   = 12'b0000_0000_0010,
        S_SHARE_WAIT = 12'b0000_0000_0100,
        S_IDLE       = 12'b0000_0000_1000,
        S_HASH_A     = 12'b0000_0001_0000,
        S_HASH_B     = 12'b0000_0010_0000,
        S_DIV        = 12'b0000_0100_0000,
        S_ENQ_RD     = 12'b0000_1000_0000,
        S_ENQ_UPD    = 12'b0001_0000_0000,
        S_DEQ_RD     = 12'b0010_0000_0000,
        S_DEQ_UPD    = 12'b0100_0000_0000,
        S_RESULT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && !cfg_we;
    assign accept  = s_ready && s_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_SHARE_GO;
                end
            end
            S_SHARE_GO:
            begin
                cmd.div_start = !cfg_we;
                cmd.div_share = 1'b1;
                if (!cfg_we)
                begin
                    state_next = S_SHARE_WAIT;
                end
            end
            S_SHARE_WAIT:
            begin
                cmd.div_share = 1'b1;
                if (cfg_we)
                begin
                    state_next = S_SHARE_GO;
                end
                else if (!status.div_busy)
                begin
                    cmd.share_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_SHARE_GO;
                end
                else if (accept)
                begin
                    if (req_type == sfq_pkg::REQ_ENQ)
                    begin
                        state_next = S_HASH_A;
                    end
                    else if (status.ring_empty)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_DEQ_RD;
                    end
                end
            end
            S_HASH_A:
            begin
                cmd.hash_a = 1'b1;
                state_next = S_HASH_B;
            end
            S_HASH_B:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_ENQ_RD;
                end
            end
            S_ENQ_RD:
            begin
                cmd.enq_rd = 1'b1;
                state_next = S_ENQ_UPD;
            end
            S_ENQ_UPD:
            begin
                cmd.enq_upd = 1'b1;
                state_next  = S_RESULT;
            end
            S_DEQ_RD:
            begin
                cmd.deq_rd = 1'b1;
                state_next = S_DEQ_UPD;
            end
            S_DEQ_UPD:
            begin
                cmd.deq_upd = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Requests are only taken from idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HASH_A || state_reg == S_DEQ_RD
                    || state_reg == S_RESULT))
        else $error("accepted request did not start");

    // Every served request delivers a result before the next is taken
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE || state_reg == S_SHARE_GO))
        else $error("result load left controller busy");

    // The sweep runs straight into the fair share update
    a_clear_share: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && status.clear_last) |=> (state_reg == S_SHARE_GO))
        else $error("clear sweep did not hand over");

endmodule

### sv/stochastic_fair_queue_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// stochastic_fair_queue_scheduler: admission and round-robin core of SFQ
// Hashes flows to buckets, admits or drops enqueues, serves active buckets.
// ============================================================================
// Usage:
//   s_axis carries one request: tuser is the kind (0 enqueue, 1 dequeue),
//   tdata the source and destination addresses used for hashing.
//   m_axis returns one result per request: served/admitted flag, bucket
//   index and the packet total after the operation. Packet storage is
//   kept outside; only bucket indices come back.
//   cfg_we/cfg_addr/cfg_wdata write queue_limit (0) or bucket_count (1);
//   write only while no request is in flight. Each write recomputes the
//   fair share on the shared divider, with tready low meanwhile.
//   Steps: an enqueue runs the key mix, the bit-serial remainder by the
//   bucket count, the depth read, the admission update and the result;
//   a dequeue the ring read, the depth read and update and the result,
//   an empty one only the result; a new request waits for the result load.
//   Reset: the bucket depth store is swept to zero, one entry a cycle,
//   then the fair share is computed; tready stays low through both.
//   Stall: a result waits in the output register; the next request is
//   still accepted and its result is held back until the register frees.
// ============================================================================
module stochastic_fair_queue_scheduler #(
    parameter int MAX_BUCKETS = sfq_pkg::MAX_BUCKETS_DEF,
    parameter int COUNT_WIDTH = sfq_pkg::COUNT_WIDTH_DEF,
    localparam int BIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int BCNT_W = $clog2(MAX_BUCKETS + 1),
    localparam int CFG_W  = (COUNT_WIDTH > BCNT_W) ? COUNT_WIDTH : BCNT_W,
    localparam int OUT_W  = ((1 + BIDX_W + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*sfq_pkg::HASH_W-1:0]   s_axis_tdata,  // src_addr, dst_addr
    input  logic                           s_axis_tuser,  // req_type
    // Result channel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata,  // ok, bucket_index, total_queued
    // Configuration
    input  logic                           cfg_we,
    input  logic [sfq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]               cfg_wdata
);

    localparam int HW = sfq_pkg::HASH_W;

    sfq_pkg::sfq_cmd_t      cmd;
    sfq_pkg::sfq_status_t   status;
    logic                   ok;
    logic [BIDX_W-1:0]      bucket_index;
    logic [COUNT_WIDTH-1:0] total_queued;

    // Sequencing: sweep, share update, request steps
    sfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .req_type (s_axis_tuser),
        .cfg_we   (cfg_we),
        .status   (status),
        .s_ready  (s_axis_tready),
        .cmd      (cmd)
    );

    // Hash, admission, stores and result register
    sfq_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .src_addr     (s_axis_tdata[HW-1:0]),
        .dst_addr     (s_axis_tdata[2*HW-1:HW]),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .m_ready      (m_axis_tready),
        .m_valid      (m_axis_tvalid),
        .ok           (ok),
        .bucket_index (bucket_index),
        .total_queued (total_queued)
    );

    // Pack result fields from the lowest bit up, zero-fill to whole bytes
    assign m_axis_tdata = OUT_W'({total_queued, bucket_index, ok});

endmodule
